/* src/video_port_and_ppi_io_top_defines.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef VIDEO_PORT_AND_PPI_IO_TOP_DEFINES_SVH
`define VIDEO_PORT_AND_PPI_IO_TOP_DEFINES_SVH

// condition in this cycle implies consequence in the next cycle
`define VPIO_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("vpio check failed");

// condition implies consequence in the same cycle
`define VPIO_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("vpio check failed");

`endif

/* src/vpio_pkg.sv */
// ----------------------------------------------------------------------------
// vpio_pkg
// types and constants of the video port and parallel port decoder
// ----------------------------------------------------------------------------
package vpio_pkg;

  localparam int VRAM_ADDR_BITS = 14;
  localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;

  typedef logic [VRAM_ADDR_BITS-1:0] vaddr_t;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // port numbers
  localparam logic [7:0] PORT_SLOT     = 8'ha8;
  localparam logic [7:0] PORT_B        = 8'ha9;
  localparam logic [7:0] PORT_C        = 8'haa;
  localparam logic [7:0] PORT_PPI_CTRL = 8'hab;
  localparam logic [7:0] PORT_VDP_DATA = 8'h98;
  localparam logic [7:0] PORT_VDP_CTRL = 8'h99;

  // second control byte commands (bits 7..6)
  localparam logic [1:0] CMD_READ = 2'b00;
  localparam logic [1:0] CMD_REG  = 2'b10;

  // ppi control bits
  localparam int CTRL_C_LO_IN = 0;
  localparam int CTRL_B_IN    = 1;
  localparam int CTRL_C_HI_IN = 3;
  localparam int CTRL_A_IN    = 4;
  localparam int CTRL_MODE    = 7;

  // video status and interrupt enable
  localparam logic [7:0] STATUS_VBLANK = 8'h80;
  localparam logic [7:0] STATUS_KEEP   = 8'h1f;
  localparam int         REG_IE        = 1;
  localparam int         IE_BIT        = 5;

  localparam logic [7:0]  BYTE_ONES = 8'hff;
  localparam logic [15:0] NO_KEYS   = 16'hffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  port;
    logic [7:0]  wdata;
    logic [15:0] key_code;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic [7:0] mapped_slots;
  } result_t;

  typedef struct packed {
    logic       we;
    logic       re;
    vaddr_t     waddr;
    vaddr_t     raddr;
    logic [7:0] wdata;
  } ram_req_t;

endpackage

/* src/vpio_ram.sv */
// ----------------------------------------------------------------------------
// vpio_ram
// video memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module vpio_ram (
  input  logic                clk,
  input  vpio_pkg::ram_req_t  req,
  output logic [7:0]          q
);

  logic [7:0] mem [vpio_pkg::VRAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.raddr];
    end
  end

endmodule

/* src/vpio_core.sv */
// ----------------------------------------------------------------------------
// vpio_core
// port decode, latches, video control state and read-ahead forwarding
// ----------------------------------------------------------------------------
module vpio_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  vpio_pkg::item_t     item,
  input  logic [7:0]          ram_q,
  output vpio_pkg::ram_req_t  ram_req,
  output vpio_pkg::result_t   result
);

  logic [7:0]       slot_select, slot_select_next;
  logic [7:0]       port_b_latch, port_b_latch_next;
  logic [7:0]       port_c_latch, port_c_latch_next;
  logic [7:0]       ppi_control, ppi_control_next;
  logic [7:0]       video_regs [8];
  logic [7:0]       video_regs_next [8];
  logic [7:0]       video_status, video_status_next;
  logic [7:0]       first_byte_latch, first_byte_latch_next;
  logic             second_byte_pending, second_byte_pending_next;
  vpio_pkg::vaddr_t video_address, video_address_next;
  logic [7:0]       read_ahead, read_ahead_next;
  logic             ra_pending, ra_pending_next;
  logic [15:0]      pressed_keys, pressed_keys_next;
  logic             irq_pending, irq_pending_next;

  logic [7:0]       ra_eff;
  logic [7:0]       rdata;
  logic [3:0]       row;
  logic [7:0]       key_bits;
  vpio_pkg::vaddr_t addr_inc;
  vpio_pkg::vaddr_t new_addr;
  logic [15:0]      addr_word;

  // refill data is still in the ram output register
  assign ra_eff    = ra_pending ? ram_q : read_ahead;
  assign addr_inc  = video_address + 1'b1;
  assign addr_word = {item.wdata, first_byte_latch};
  assign new_addr  = addr_word[vpio_pkg::VRAM_ADDR_BITS-1:0];

  // keyboard matrix scan, two keys at most
  always_comb begin
    row      = ppi_control[vpio_pkg::CTRL_C_LO_IN] ? 4'd0 : port_c_latch[3:0];
    key_bits = '0;
    if (pressed_keys[7:4] == row && !pressed_keys[3]) begin
      key_bits[pressed_keys[2:0]] = 1'b1;
    end
    if (pressed_keys[15:12] == row && !pressed_keys[11]) begin
      key_bits[pressed_keys[10:8]] = 1'b1;
    end
  end

  always_comb begin
    slot_select_next         = slot_select;
    port_b_latch_next        = port_b_latch;
    port_c_latch_next        = port_c_latch;
    ppi_control_next         = ppi_control;
    video_regs_next          = video_regs;
    video_status_next        = video_status;
    first_byte_latch_next    = first_byte_latch;
    second_byte_pending_next = second_byte_pending;
    video_address_next       = video_address;
    read_ahead_next          = ra_eff;
    ra_pending_next          = 1'b0;
    pressed_keys_next        = pressed_keys;
    irq_pending_next         = irq_pending;
    ram_req                  = '0;
    rdata                    = vpio_pkg::BYTE_ONES;

    if (fire) begin
      case (item.mode)
        vpio_pkg::MODE_READ: begin
          case (item.port)
            vpio_pkg::PORT_SLOT: begin
              rdata = ppi_control[vpio_pkg::CTRL_A_IN] ? vpio_pkg::BYTE_ONES : slot_select;
            end
            vpio_pkg::PORT_B: begin
              rdata = ppi_control[vpio_pkg::CTRL_B_IN] ? ~key_bits : port_b_latch;
            end
            vpio_pkg::PORT_C: begin
              rdata[3:0] = ppi_control[vpio_pkg::CTRL_C_LO_IN] ? 4'hf : port_c_latch[3:0];
              rdata[7:4] = ppi_control[vpio_pkg::CTRL_C_HI_IN] ? 4'hf : port_c_latch[7:4];
            end
            vpio_pkg::PORT_PPI_CTRL: begin
              rdata = ppi_control;
            end
            vpio_pkg::PORT_VDP_DATA: begin
              rdata                    = ra_eff;
              ram_req.re               = 1'b1;
              ram_req.raddr            = video_address;
              video_address_next       = addr_inc;
              ra_pending_next          = 1'b1;
              second_byte_pending_next = 1'b0;
            end
            vpio_pkg::PORT_VDP_CTRL: begin
              rdata             = video_status;
              video_status_next = video_status & vpio_pkg::STATUS_KEEP;
              irq_pending_next  = 1'b0;
            end
            default: begin
            end
          endcase
        end
        vpio_pkg::MODE_WRITE: begin
          case (item.port)
            vpio_pkg::PORT_SLOT:     slot_select_next  = item.wdata;
            vpio_pkg::PORT_B:        port_b_latch_next = item.wdata;
            vpio_pkg::PORT_C:        port_c_latch_next = item.wdata;
            vpio_pkg::PORT_PPI_CTRL: begin
              if (item.wdata[vpio_pkg::CTRL_MODE]) begin
                ppi_control_next = item.wdata;
              end else begin
                port_c_latch_next[item.wdata[3:1]] = item.wdata[0];
              end
            end
            vpio_pkg::PORT_VDP_DATA: begin
              ram_req.we               = 1'b1;
              ram_req.waddr            = video_address;
              ram_req.wdata            = item.wdata;
              video_address_next       = addr_inc;
              second_byte_pending_next = 1'b0;
              read_ahead_next          = item.wdata;
            end
            vpio_pkg::PORT_VDP_CTRL: begin
              if (second_byte_pending) begin
                second_byte_pending_next = 1'b0;
                video_address_next       = new_addr;
                if (item.wdata[7:6] == vpio_pkg::CMD_REG) begin
                  video_regs_next[item.wdata[2:0]] = first_byte_latch;
                end else if (item.wdata[7:6] == vpio_pkg::CMD_READ) begin
                  ram_req.re         = 1'b1;
                  ram_req.raddr      = new_addr;
                  video_address_next = new_addr + 1'b1;
                  ra_pending_next    = 1'b1;
                end
              end else begin
                second_byte_pending_next = 1'b1;
                first_byte_latch_next    = item.wdata;
              end
            end
            default: begin
            end
          endcase
        end
        vpio_pkg::MODE_TICK: begin
          video_status_next = video_status | vpio_pkg::STATUS_VBLANK;
          if (video_regs[vpio_pkg::REG_IE][vpio_pkg::IE_BIT]) begin
            irq_pending_next = 1'b1;
          end
          pressed_keys_next = item.key_code;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.rdata        = rdata;
    result.irq          = irq_pending_next;
    result.mapped_slots = ppi_control_next[vpio_pkg::CTRL_A_IN] ? 8'h00 : slot_select_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_select         <= '0;
      port_b_latch        <= '0;
      port_c_latch        <= '0;
      ppi_control         <= '0;
      video_regs          <= '{default: '0};
      video_status        <= '0;
      first_byte_latch    <= '0;
      second_byte_pending <= 1'b0;
      video_address       <= '0;
      read_ahead          <= '0;
      ra_pending          <= 1'b0;
      pressed_keys        <= vpio_pkg::NO_KEYS;
      irq_pending         <= 1'b0;
    end else begin
      slot_select         <= slot_select_next;
      port_b_latch        <= port_b_latch_next;
      port_c_latch        <= port_c_latch_next;
      ppi_control         <= ppi_control_next;
      video_regs          <= video_regs_next;
      video_status        <= video_status_next;
      first_byte_latch    <= first_byte_latch_next;
      second_byte_pending <= second_byte_pending_next;
      video_address       <= video_address_next;
      read_ahead          <= read_ahead_next;
      ra_pending          <= ra_pending_next;
      pressed_keys        <= pressed_keys_next;
      irq_pending         <= irq_pending_next;
    end
  end

endmodule

/* src/vpio_outbuf.sv */
// ----------------------------------------------------------------------------
// vpio_outbuf
// result register with one skid entry
// ----------------------------------------------------------------------------
module vpio_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  vpio_pkg::result_t  din,
  output logic               full,
  output logic               result_valid,
  input  logic               result_stall,
  output vpio_pkg::result_t  result
);

  logic              skid_valid;
  vpio_pkg::result_t skid;
  logic              taken;
  logic              to_main;

  assign taken   = result_valid && !result_stall;
  assign to_main = !result_valid || !result_stall;
  assign full    = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (taken) begin
        result_valid <= skid_valid;
        skid_valid   <= 1'b0;
      end
      if (fire) begin
        if (to_main) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (taken && skid_valid) begin
      result <= skid;
    end else if (fire && to_main) begin
      result <= din;
    end
    if (fire && !to_main) begin
      skid <= din;
    end
  end

endmodule

/* src/video_port_and_ppi_io_top.sv */
// ----------------------------------------------------------------------------
// video_port_and_ppi_io_top
// i/o port decoder: parallel port with slot select and keyboard, video port
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid, item_stall, item): one port read, port write,
//   frame tick or no-op per transaction; result channel (result_valid,
//   result_stall, result): exactly one result transaction per item, in order
//   a taken item's result is registered in the output register, or in the
//   skid entry behind a stalled result; one item per cycle while item_stall
//   is low: a read-ahead refill issued by one item lands in the ram output
//   register next cycle, is forwarded to the next item, so no bubble is needed
//   reset (rst, synchronous): all latches, video registers and status clear,
//   no keys pressed, both channels empty; video memory keeps its contents and
//   is undefined until written; item_stall is held high while rst is high
//   receiver stall: the result register holds, one more result goes to a
//   skid entry, then item_stall rises (it comes from a flop, not from
//   result_stall) until the receiver takes a result
// ----------------------------------------------------------------------------
module video_port_and_ppi_io_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  vpio_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output vpio_pkg::result_t  result
);

  logic               fire;
  logic               full;
  logic [7:0]         ram_q;
  vpio_pkg::ram_req_t ram_req;
  vpio_pkg::result_t  core_result;

  // take an item whenever the skid entry is free and reset is over
  assign item_stall = full || rst;
  assign fire       = item_valid && !item_stall;

  // decode and state, issues memory accesses
  vpio_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (item),
    .ram_q   (ram_q),
    .ram_req (ram_req),
    .result  (core_result)
  );

  // video memory
  vpio_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .q   (ram_q)
  );

  // output register and skid
  vpio_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .din          (core_result),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* src/vpio_checker.sv */
// ----------------------------------------------------------------------------
// vpio_checker
// port level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "video_port_and_ppi_io_top_defines.svh"

module vpio_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input vpio_pkg::result_t result
);

  // a stalled result stays
  `VPIO_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  // and keeps its value
  `VPIO_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))
  // input stalls only behind a waiting result
  `VPIO_ASSERT_NOW(a_stall_needs_result, item_stall, result_valid)
  // an item taken into an empty block shows its result next cycle
  `VPIO_ASSERT_NEXT(a_item_result, item_valid && !item_stall && !result_valid, result_valid)

endmodule

bind video_port_and_ppi_io_top vpio_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the video port and parallel port decoder: drives
// port reads, port writes and frame ticks through the item channel, predicts
// each result from its own copy of the decoder state and checks every result
// transaction field by field, in order
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // mode 3 does nothing at all, second byte commands 01 and 11 only load
  localparam logic [1:0] MODE_NOP      = 2'd3;
  localparam logic [1:0] CMD_ADDR_ONLY = 2'b01;
  localparam logic [1:0] CMD_LOAD_ONLY = 2'b11;

  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES = 8;     // quiet time after the last result
  localparam int SHOW_MAX    = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  vpio_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  vpio_pkg::result_t result;

  video_port_and_ppi_io_top uut (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .item,
    .result_valid,
    .result_stall,
    .result
  );

  always #1 clk = ~clk;

  // ------------------------------------------------------------------------
  // decoder state as the bench sees it, updated once per accepted item
  // ------------------------------------------------------------------------
  logic [7:0]       slot_sel    = '0;
  logic [7:0]       pb_latch    = '0;
  logic [7:0]       pc_latch    = '0;
  logic [7:0]       ppi_ctrl    = '0;
  logic [7:0]       vdp_reg [8] = '{default: '0};
  logic [7:0]       vdp_status  = '0;
  logic [7:0]       ctrl_first  = '0;
  logic             ctrl_second = 1'b0;
  vpio_pkg::vaddr_t vdp_addr    = '0;
  logic [7:0]       prefetch    = '0;
  logic [15:0]      keys_down   = vpio_pkg::NO_KEYS;
  logic             irq_level   = 1'b0;

  // video memory image plus a map of entries written so far
  logic [7:0]  vram_img     [vpio_pkg::VRAM_DEPTH];
  bit          vram_written [vpio_pkg::VRAM_DEPTH];

  // one expected result per accepted item, oldest first
  vpio_pkg::result_t io_results_due [$];

  int n_items      = 0;
  int n_results    = 0;
  int n_vram_reads = 0;
  int n_ticks      = 0;
  int fail_count   = 0;

  // idling control shared by sender and receiver
  bit steady       = 1'b0;
  int hold_request = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  // ------------------------------------------------------------------------
  // expected behavior
  // ------------------------------------------------------------------------

  // data port fetch: hand out the buffered byte, refill it, step the address
  function automatic logic [7:0] vram_fetch();
    logic [7:0] prev;
    prev        = prefetch;
    prefetch    = vram_img[vdp_addr];
    vdp_addr    = vdp_addr + 1'b1;
    ctrl_second = 1'b0;
    n_vram_reads++;
    return prev;
  endfunction

  function automatic vpio_pkg::result_t port_access(input vpio_pkg::item_t it);
    vpio_pkg::result_t r;
    logic [3:0]        row;
    logic [15:0]       hits;
    logic [15:0]       addr16;
    r.rdata = vpio_pkg::BYTE_ONES;
    case (it.mode)
      vpio_pkg::MODE_READ: begin
        case (it.port)
          vpio_pkg::PORT_SLOT: begin
            r.rdata = ppi_ctrl[vpio_pkg::CTRL_A_IN] ? vpio_pkg::BYTE_ONES : slot_sel;
          end
          vpio_pkg::PORT_B: begin
            if (ppi_ctrl[vpio_pkg::CTRL_B_IN]) begin
              // keyboard scan, row from port C low unless that nibble is input
              row  = ppi_ctrl[vpio_pkg::CTRL_C_LO_IN] ? 4'h0 : pc_latch[3:0];
              hits = '0;
              if (keys_down[7:4] == row) hits[keys_down[3:0]] = 1'b1;
              if (keys_down[15:12] == row) hits[keys_down[11:8]] = 1'b1;
              r.rdata = ~hits[7:0];
            end else begin
              r.rdata = pb_latch;
            end
          end
          vpio_pkg::PORT_C: begin
            r.rdata = {ppi_ctrl[vpio_pkg::CTRL_C_HI_IN] ? 4'hf : pc_latch[7:4],
                       ppi_ctrl[vpio_pkg::CTRL_C_LO_IN] ? 4'hf : pc_latch[3:0]};
          end
          vpio_pkg::PORT_PPI_CTRL: r.rdata = ppi_ctrl;
          vpio_pkg::PORT_VDP_DATA: r.rdata = vram_fetch();
          vpio_pkg::PORT_VDP_CTRL: begin
            r.rdata    = vdp_status;
            vdp_status = vdp_status & vpio_pkg::STATUS_KEEP;
            irq_level  = 1'b0;
          end
          default: ;
        endcase
      end
      vpio_pkg::MODE_WRITE: begin
        case (it.port)
          vpio_pkg::PORT_SLOT: slot_sel = it.wdata;
          vpio_pkg::PORT_B:    pb_latch = it.wdata;
          vpio_pkg::PORT_C:    pc_latch = it.wdata;
          vpio_pkg::PORT_PPI_CTRL: begin
            if (it.wdata[vpio_pkg::CTRL_MODE]) ppi_ctrl = it.wdata;
            else pc_latch[it.wdata[3:1]] = it.wdata[0];
          end
          vpio_pkg::PORT_VDP_DATA: begin
            vram_img[vdp_addr]     = it.wdata;
            vram_written[vdp_addr] = 1'b1;
            vdp_addr               = vdp_addr + 1'b1;
            ctrl_second            = 1'b0;
            prefetch               = it.wdata;
          end
          vpio_pkg::PORT_VDP_CTRL: begin
            if (ctrl_second) begin
              ctrl_second = 1'b0;
              addr16      = {it.wdata, ctrl_first};
              vdp_addr    = addr16[vpio_pkg::VRAM_ADDR_BITS-1:0];
              if (it.wdata[7:6] == vpio_pkg::CMD_REG) vdp_reg[it.wdata[2:0]] = ctrl_first;
              else if (it.wdata[7:6] == vpio_pkg::CMD_READ) void'(vram_fetch());
            end else begin
              ctrl_second = 1'b1;
              ctrl_first  = it.wdata;
            end
          end
          default: ;
        endcase
      end
      vpio_pkg::MODE_TICK: begin
        vdp_status = vdp_status | vpio_pkg::STATUS_VBLANK;
        if (vdp_reg[vpio_pkg::REG_IE][vpio_pkg::IE_BIT]) irq_level = 1'b1;
        keys_down = it.key_code;
        n_ticks++;
      end
      default: ;  // no operation
    endcase
    r.irq          = irq_level;
    r.mapped_slots = ppi_ctrl[vpio_pkg::CTRL_A_IN] ? 8'h00 : slot_sel;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------------
  function automatic vpio_pkg::item_t make_access(input logic [1:0] mode,
                                                  input logic [7:0] port,
                                                  input logic [7:0] wdata,
                                                  input logic [15:0] keys);
    vpio_pkg::item_t it;
    it.mode     = mode;
    it.port     = port;
    it.wdata    = wdata;
    it.key_code = keys;
    return it;
  endfunction

  // one transaction on the item channel, prediction once it is taken
  task automatic issue_access(input vpio_pkg::item_t it);
    logic [15:0] target;
    target = {it.wdata, ctrl_first};
    // never let the block fetch a video memory byte that was never written
    if (it.mode == vpio_pkg::MODE_READ && it.port == vpio_pkg::PORT_VDP_DATA &&
        !vram_written[vdp_addr])
      it.mode = vpio_pkg::MODE_WRITE;
    if (it.mode == vpio_pkg::MODE_WRITE && it.port == vpio_pkg::PORT_VDP_CTRL &&
        ctrl_second && it.wdata[7:6] == vpio_pkg::CMD_READ &&
        !vram_written[target[vpio_pkg::VRAM_ADDR_BITS-1:0]])
      it.wdata[6] = 1'b1;
    // random idle cycles before the transaction
    while (!steady && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    io_results_due.push_back(port_access(it));
    n_items++;
  endtask

  task automatic port_wr(input logic [7:0] port, input logic [7:0] data);
    issue_access(make_access(vpio_pkg::MODE_WRITE, port, data, 16'($urandom)));
  endtask

  task automatic port_rd(input logic [7:0] port);
    issue_access(make_access(vpio_pkg::MODE_READ, port, 8'($urandom), 16'($urandom)));
  endtask

  task automatic frame_tick(input logic [15:0] keys);
    issue_access(make_access(vpio_pkg::MODE_TICK, 8'($urandom), 8'($urandom), keys));
  endtask

  // control port writes: flush a pending first byte, low address byte, then command and high bits
  task automatic set_vram_addr(input vpio_pkg::vaddr_t a, input logic [1:0] cmd);
    if (ctrl_second) port_wr(vpio_pkg::PORT_VDP_CTRL, {CMD_ADDR_ONLY, 6'h00});
    port_wr(vpio_pkg::PORT_VDP_CTRL, a[7:0]);
    port_wr(vpio_pkg::PORT_VDP_CTRL, {cmd, 6'(a >> 8)});
  endtask

  task automatic vdp_reg_wr(input logic [2:0] idx, input logic [7:0] value);
    port_wr(vpio_pkg::PORT_VDP_CTRL, value);
    port_wr(vpio_pkg::PORT_VDP_CTRL, {vpio_pkg::CMD_REG, 3'($urandom), idx});
  endtask

  // mostly small windows at both ends of memory so that reads find data
  function automatic vpio_pkg::vaddr_t pick_vram_addr();
    case ($urandom_range(4))
      0, 1, 2: return vpio_pkg::vaddr_t'($urandom_range(127));
      3:       return vpio_pkg::vaddr_t'(vpio_pkg::VRAM_DEPTH - 128 + $urandom_range(127));
      default: return vpio_pkg::vaddr_t'($urandom);
    endcase
  endfunction

  // well-formed access sequences with random content, plus some noise
  task automatic run_random_traffic(input int count);
    int          stop_at;
    int          pick;
    int          len;
    logic [7:0]  value;
    logic [15:0] keys;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      pick = $urandom_range(99);
      len  = $urandom_range(1, 8);
      if (pick < 20) begin
        // video memory write burst
        set_vram_addr(pick_vram_addr(), $urandom_range(1) ? CMD_ADDR_ONLY : CMD_LOAD_ONLY);
        repeat (len) port_wr(vpio_pkg::PORT_VDP_DATA, 8'($urandom));
      end else if (pick < 40) begin
        // read-ahead setup then read burst
        set_vram_addr(pick_vram_addr(), vpio_pkg::CMD_READ);
        repeat (len) port_rd(vpio_pkg::PORT_VDP_DATA);
      end else if (pick < 48) begin
        value = 8'($urandom);
        vdp_reg_wr($urandom_range(1) ? 3'(vpio_pkg::REG_IE) : 3'($urandom), value);
      end else if (pick < 58) begin
        // keys often on the row that port C selects
        keys[7:0]  = {$urandom_range(1) ? pc_latch[3:0] : 4'($urandom), 4'($urandom)};
        keys[15:8] = {$urandom_range(1) ? pc_latch[3:0] : 4'($urandom), 4'($urandom)};
        frame_tick($urandom_range(7) == 0 ? vpio_pkg::NO_KEYS : keys);
      end else if (pick < 66) begin
        port_rd(vpio_pkg::PORT_VDP_CTRL);
      end else if (pick < 84) begin
        case ($urandom_range(3))
          0:       value = vpio_pkg::PORT_SLOT;
          1:       value = vpio_pkg::PORT_B;
          2:       value = vpio_pkg::PORT_C;
          default: value = vpio_pkg::PORT_PPI_CTRL;
        endcase
        if ($urandom_range(1)) port_rd(value);
        else port_wr(value, 8'($urandom));
      end else begin
        // noise: any mode, any port, half the time a decoded one
        value = $urandom_range(1) ? 8'($urandom) :
                ($urandom_range(1) ? vpio_pkg::PORT_VDP_DATA : vpio_pkg::PORT_VDP_CTRL);
        issue_access(make_access(2'($urandom), value, 8'($urandom), 16'($urandom)));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // slot select, port A input, port C nibbles, bit set/reset, key scan
  task automatic test_parallel_port();
    port_wr(vpio_pkg::PORT_SLOT, 8'hff);
    port_wr(vpio_pkg::PORT_PPI_CTRL, 8'h9b);    // every port input
    port_rd(vpio_pkg::PORT_SLOT);
    port_rd(vpio_pkg::PORT_C);
    port_wr(vpio_pkg::PORT_C, 8'h03);
    port_wr(vpio_pkg::PORT_PPI_CTRL, 8'h82);    // only port B input
    port_wr(vpio_pkg::PORT_PPI_CTRL, 8'h0f);    // set port C bit 7
    port_wr(vpio_pkg::PORT_PPI_CTRL, 8'h00);    // clear port C bit 0
    frame_tick(16'h2a25);                       // two keys on row 2, one beyond column 7
    port_rd(vpio_pkg::PORT_B);
    port_rd(vpio_pkg::PORT_PPI_CTRL);
    port_rd(8'h00);                             // undecoded ports
    port_wr(8'hff, 8'h00);
  endtask

  // address wrap, read-ahead, registers, status and interrupt, no operation
  task automatic test_video_port();
    set_vram_addr(vpio_pkg::vaddr_t'(vpio_pkg::VRAM_DEPTH - 1), CMD_ADDR_ONLY);
    port_wr(vpio_pkg::PORT_VDP_DATA, 8'ha5);    // last entry, address wraps to zero
    port_wr(vpio_pkg::PORT_VDP_DATA, 8'h3c);
    set_vram_addr(vpio_pkg::vaddr_t'(vpio_pkg::VRAM_DEPTH - 1), vpio_pkg::CMD_READ);
    port_rd(vpio_pkg::PORT_VDP_DATA);
    vdp_reg_wr(3'(vpio_pkg::REG_IE), 8'h20);    // interrupt enable
    frame_tick(vpio_pkg::NO_KEYS);
    vdp_reg_wr(3'(vpio_pkg::REG_IE), 8'h00);
    frame_tick(16'hffff);                       // interrupts off, irq keeps its level
    port_rd(vpio_pkg::PORT_VDP_CTRL);
    set_vram_addr(vpio_pkg::vaddr_t'(14'h0712), CMD_LOAD_ONLY);
    issue_access(make_access(MODE_NOP, vpio_pkg::PORT_VDP_CTRL, 8'hff, 16'h0000));
  endtask

  task automatic test_random_traffic(input int count);
    run_random_traffic(count);
  endtask

  // receiver holds off while items keep coming, so the block fills up
  task automatic test_result_backpressure();
    hold_request++;
    run_random_traffic(40);
  endtask

  // sender stops until every expected result is in
  task automatic test_sender_pause();
    item_valid <= 1'b0;
    while (io_results_due.size() != 0) @(posedge clk);
    run_random_traffic(50);
  endtask

  // back to back transactions, no idling on either side
  task automatic test_gap_free_stream();
    steady = 1'b1;
    run_random_traffic(300);
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_parallel_port();
    test_video_port();
    test_random_traffic(400);
    test_result_backpressure();
    test_sender_pause();
    test_gap_free_stream();
    test_random_traffic(250);
    // drain, then give the block time to show any stray result
    item_valid <= 1'b0;
    while (io_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d port accesses and %0d results: %0d video memory fetches, %0d ticks",
             n_items, n_results, n_vram_reads, n_ticks);
    $display("with a long result hold-off, a drained sender pause and a gap-free stretch");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // receiver: random stall, with a counted hold-off on request
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_seen != hold_request) begin
      hold_seen    <= hold_request;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 11);
    end
  end

  // ------------------------------------------------------------------------
  // result check against the oldest expectation
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    vpio_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (io_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("unexpected result transaction: rdata %h irq %b slots %h",
                   result.rdata, result.irq, result.mapped_slots);
      end else begin
        want = io_results_due.pop_front();
        if (result.rdata !== want.rdata || result.irq !== want.irq ||
            result.mapped_slots !== want.mapped_slots) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("result %0d mismatch: expected rdata %h irq %b slots %h, got %h %b %h",
                     n_results, want.rdata, want.irq, want.mapped_slots,
                     result.rdata, result.irq, result.mapped_slots);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results still due",
               STALL_LIMIT, io_results_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
